[sv/stq_pkg.sv]
`timescale 1ns / 1ps
package stq_pkg;

  localparam int DEPTH    = 16;
  localparam int MAX_FIRE = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int SUM_W    = IDX_W + 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

  localparam logic       ACT_ADD    = 1'b0;
  localparam logic       ACT_TICK   = 1'b1;
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_ADDED = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [3:0]  task_id;
    logic        periodic;
    logic [15:0] interval;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] fired_id;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [31:0] expiry;
    logic [15:0] period;
    logic [3:0]  ident;
    logic        rearm;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_START,
    S_INS_RD,
    S_INS_CHK,
    S_INS_PUT,
    S_ADD_RESP,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_FIRE,
    S_DONE
  } state_t;

  // a strictly later than b, by wrapped signed difference
  function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

  // ring position of logical slot off, counted from base
  function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

[sv/stq_ram.sv]
`timescale 1ns / 1ps
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/sorted_timer_queue.sv]
`timescale 1ns / 1ps
// add word: the new entry lands at the tail, after each later entry has moved one slot back
//   (a full table gets a full result and no insert; the insert walks back from the tail through one ram port)
// tick word: time advances, then due tasks fire from the head, plus the insert walk of each periodic re-arm
// one word in flight; cmd_ready is high only while idle, results wait in a one-word output register
// reset clears the time counter, the ring head and the entry count; entry memory is not cleared
module sorted_timer_queue
  import stq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // control state
  state_t            state, state_next;
  logic [31:0]       now_ticks, now_ticks_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  idx, idx_next;          // logical slot under test during insert
  logic [FIRE_W-1:0] fire_n, fire_n_next;    // tasks fired by this tick
  logic              tick_mode, tick_mode_next;
  logic              pend_valid, pend_valid_next;
  logic              out_valid, out_valid_next;

  // payload
  logic [3:0]        pend_id, pend_id_next;  // fired task held until its last flag is known
  entry_t            cur, cur_next;          // head entry being fired
  entry_t            new_e, new_e_next;      // entry being inserted
  logic [1:0]        add_kind, add_kind_next;
  res_t              out_word, out_word_next;

  // entry memory ports
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t            rd_e;

  logic              out_free;
  logic [15:0]       ivl;

  assign rd_e      = entry_t'(mem_rdata);
  assign out_free  = !out_valid || res_ready;
  assign cmd_ready = (state == S_IDLE);
  assign res_valid = out_valid;
  assign res       = out_word;
  // a zero interval counts as one tick
  assign ivl       = (cmd.interval == 16'd0) ? 16'd1 : cmd.interval;

  stq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next      = state;
    now_ticks_next  = now_ticks;
    head_next       = head;
    count_next      = count;
    idx_next        = idx;
    fire_n_next     = fire_n;
    tick_mode_next  = tick_mode;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    cur_next        = cur;
    new_e_next      = new_e;
    add_kind_next   = add_kind;
    out_valid_next  = out_valid && !res_ready;
    out_word_next   = out_word;
    mem_we          = 1'b0;
    mem_waddr       = ring_addr(head, idx + 1'b1);
    mem_wdata       = new_e;
    mem_raddr       = ring_addr(head, idx);

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.action == ACT_ADD) begin
            tick_mode_next = 1'b0;
            new_e_next     = '{expiry: now_ticks + {16'd0, ivl}, period: ivl,
                               ident: cmd.task_id, rearm: cmd.periodic};
            if (count == CNT_W'(DEPTH)) begin
              add_kind_next = KIND_FULL;
              state_next    = S_ADD_RESP;
            end else begin
              add_kind_next = KIND_ADDED;
              state_next    = S_INS_START;
            end
          end else begin
            // time advances first, then the head is checked
            tick_mode_next  = 1'b1;
            now_ticks_next  = now_ticks + 32'd1;
            fire_n_next     = '0;
            pend_valid_next = 1'b0;
            state_next      = S_HEAD_RD;
          end
        end
      end

      S_INS_START: begin
        if (count == '0) begin
          idx_next   = '0;
          state_next = S_INS_PUT;
        end else begin
          idx_next   = IDX_W'(count - 1'b1);
          state_next = S_INS_RD;
        end
      end

      S_INS_RD: begin
        // read address is the slot under test
        state_next = S_INS_CHK;
      end

      S_INS_CHK: begin
        if (later_than(rd_e.expiry, new_e.expiry)) begin
          // move this entry one slot back
          mem_we    = 1'b1;
          mem_wdata = rd_e;
          if (idx == '0) begin
            state_next = S_INS_PUT;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = S_INS_RD;
          end
        end else begin
          // ties and earlier entries stay ahead
          idx_next   = idx + 1'b1;
          state_next = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        // at the front when the walk ran out, idx is zero and address is head
        mem_we     = 1'b1;
        mem_waddr  = ring_addr(head, (state == S_INS_PUT && idx == '0) ? '0 : idx);
        mem_wdata  = new_e;
        count_next = count + 1'b1;
        state_next = tick_mode ? S_HEAD_RD : S_ADD_RESP;
      end

      S_ADD_RESP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_word_next  = '{kind: add_kind, fired_id: new_e.ident, last: 1'b1};
          state_next     = S_IDLE;
        end
      end

      S_HEAD_RD: begin
        mem_raddr = head;
        if (count == '0 || fire_n == FIRE_W'(MAX_FIRE)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_HEAD_CHK;
        end
      end

      S_HEAD_CHK: begin
        cur_next = rd_e;
        if (later_than(rd_e.expiry, now_ticks)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FIRE;
        end
      end

      S_FIRE: begin
        // a previous fire goes out now that another one follows it
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_word_next  = '{kind: KIND_FIRED, fired_id: pend_id, last: 1'b0};
          end
          pend_valid_next = 1'b1;
          pend_id_next    = cur.ident;
          fire_n_next     = fire_n + 1'b1;
          head_next       = ring_addr(head, IDX_W'(1));
          count_next      = count - 1'b1;
          if (cur.rearm) begin
            new_e_next = '{expiry: now_ticks + {16'd0, cur.period}, period: cur.period,
                           ident: cur.ident, rearm: 1'b1};
            state_next = S_INS_START;
          end else begin
            state_next = S_HEAD_RD;
          end
        end
      end

      S_DONE: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_word_next   = '{kind: KIND_FIRED, fired_id: pend_id, last: 1'b1};
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now_ticks  <= '0;
      head       <= '0;
      count      <= '0;
      idx        <= '0;
      fire_n     <= '0;
      tick_mode  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      now_ticks  <= now_ticks_next;
      head       <= head_next;
      count      <= count_next;
      idx        <= idx_next;
      fire_n     <= fire_n_next;
      tick_mode  <= tick_mode_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_id  <= pend_id_next;
    cur      <= cur_next;
    new_e    <= new_e_next;
    add_kind <= add_kind_next;
    out_word <= out_word_next;
  end

endmodule
